// ----- hw/rtl/hpq_pkg.sv -----
// ----------------------------------------------------------------------------
// hpq_pkg
// Types and constants shared by the binary heap priority queue modules.
// ----------------------------------------------------------------------------
package hpq_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int COUNT_WIDTH = 11;

	typedef enum logic [1:0] {
		ACT_INSERT = 2'd0,
		ACT_DELETE = 2'd1,
		ACT_PEEK   = 2'd2,
		ACT_CLEAR  = 2'd3
	} action_t;

	typedef struct packed {
		action_t                        action;
		logic signed [VALUE_WIDTH-1:0]  value;
	} req_t;

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0]  top_value;
		logic [COUNT_WIDTH-1:0]         entry_count;
		logic                           is_empty;
		logic                           op_error;
	} rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_LAST,
		ST_DN_LOAD,
		ST_DN_RDL,
		ST_DN_RDR,
		ST_DN_SEL,
		ST_DN_MOVE,
		ST_DONE
	} state_t;

endpackage

// ----- hw/rtl/hpq_ram.sv -----
// ----------------------------------------------------------------------------
// hpq_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module hpq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ----- hw/rtl/hpq_cmp.sv -----
// ----------------------------------------------------------------------------
// hpq_cmp
// Shared order comparator: true when a must sit strictly above b.
// ----------------------------------------------------------------------------
module hpq_cmp
	import hpq_pkg::*;
(
	input  logic                          order_mode,
	input  logic signed [VALUE_WIDTH-1:0] a,
	input  logic signed [VALUE_WIDTH-1:0] b,
	output logic                          above
);

	assign above = order_mode ? (a > b) : (a < b);

endmodule

// ----- hw/rtl/hpq_seq.sv -----
// ----------------------------------------------------------------------------
// hpq_seq
// Sift sequencer: drives the heap RAM and the shared comparator level by level.
// ----------------------------------------------------------------------------
module hpq_seq
	import hpq_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic clk,
	input  logic arst_n,
	input  logic order_mode,
	input  logic start,
	input  req_t item,
	input  logic slot_free,
	output logic busy,
	output logic done,
	output rsp_t result
);

	localparam int AW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int IW = AW + 2;

	state_t state_q, state_d;

	logic [CW-1:0]                  cnt_q, cnt_d;
	logic                           err_q, err_d;
	logic [AW-1:0]                  pos_q, pos_d;
	logic [AW-1:0]                  kidpos_q, kidpos_d;
	logic signed [VALUE_WIDTH-1:0]  cur_q, cur_d;
	logic signed [VALUE_WIDTH-1:0]  kid_q, kid_d;
	logic signed [VALUE_WIDTH-1:0]  top_q;

	logic                           we;
	logic [AW-1:0]                  waddr;
	logic signed [VALUE_WIDTH-1:0]  wdata;
	logic [AW-1:0]                  raddr;
	logic [VALUE_WIDTH-1:0]         rdata;
	logic signed [VALUE_WIDTH-1:0]  rd;

	logic signed [VALUE_WIDTH-1:0]  cmp_a, cmp_b;
	logic                           above;

	logic [AW-1:0] parent;
	logic [IW-1:0] pick;
	logic [IW-1:0] pick_r;
	logic [IW-1:0] cnt_w;

	assign rd     = $signed(rdata);
	assign parent = (pos_q - AW'(1)) >> 1;
	assign pick   = IW'({pos_q, 1'b1});
	assign pick_r = pick + IW'(1);
	assign cnt_w  = IW'(cnt_q);

	hpq_ram #(
		.WIDTH(VALUE_WIDTH),
		.DEPTH(CAPACITY)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.raddr(raddr),
		.rdata(rdata)
	);

	hpq_cmp u_cmp (
		.order_mode(order_mode),
		.a         (cmp_a),
		.b         (cmp_b),
		.above     (above)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_d;
			cnt_q   <= cnt_d;
		end
	end

	always_ff @(posedge clk) begin
		err_q    <= err_d;
		pos_q    <= pos_d;
		kidpos_q <= kidpos_d;
		cur_q    <= cur_d;
		kid_q    <= kid_d;
		if (we && waddr == '0) begin
			top_q <= wdata;
		end
	end

	always_comb begin
		state_d  = state_q;
		cnt_d    = cnt_q;
		err_d    = err_q;
		pos_d    = pos_q;
		kidpos_d = kidpos_q;
		cur_d    = cur_q;
		kid_d    = kid_q;
		we       = 1'b0;
		waddr    = pos_q;
		wdata    = cur_q;
		raddr    = parent;
		cmp_a    = cur_q;
		cmp_b    = rd;
		done     = 1'b0;

		case (state_q)
			ST_IDLE: begin
				if (start) begin
					err_d   = 1'b0;
					state_d = ST_DONE;
					case (item.action)
						ACT_INSERT: begin
							if (cnt_q == CW'(CAPACITY)) begin
								err_d = 1'b1;
							end else begin
								cur_d   = item.value;
								pos_d   = AW'(cnt_q);
								cnt_d   = cnt_q + CW'(1);
								state_d = ST_UP_RD;
							end
						end
						ACT_DELETE: begin
							if (cnt_q == '0) begin
								err_d = 1'b1;
							end else begin
								cnt_d = cnt_q - CW'(1);
								if (cnt_q != CW'(1)) begin
									state_d = ST_DN_LAST;
								end
							end
						end
						ACT_CLEAR: begin
							cnt_d = '0;
						end
						default: begin
						end
					endcase
				end
			end
			ST_UP_RD: begin
				if (pos_q == '0) begin
					we      = 1'b1;
					state_d = ST_DONE;
				end else begin
					raddr   = parent;
					state_d = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				cmp_a = cur_q;
				cmp_b = rd;
				we    = 1'b1;
				if (above) begin
					wdata   = rd;
					pos_d   = parent;
					state_d = ST_UP_RD;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DN_LAST: begin
				raddr   = AW'(cnt_q);
				state_d = ST_DN_LOAD;
			end
			ST_DN_LOAD: begin
				cur_d   = rd;
				pos_d   = '0;
				state_d = ST_DN_RDL;
			end
			ST_DN_RDL: begin
				if (pick >= cnt_w) begin
					we      = 1'b1;
					state_d = ST_DONE;
				end else begin
					raddr   = AW'(pick);
					state_d = ST_DN_RDR;
				end
			end
			ST_DN_RDR: begin
				kid_d    = rd;
				kidpos_d = AW'(pick);
				if (pick_r < cnt_w) begin
					raddr   = AW'(pick_r);
					state_d = ST_DN_SEL;
				end else begin
					state_d = ST_DN_MOVE;
				end
			end
			ST_DN_SEL: begin
				cmp_a = rd;
				cmp_b = kid_q;
				if (above) begin
					kid_d    = rd;
					kidpos_d = AW'(pick_r);
				end
				state_d = ST_DN_MOVE;
			end
			ST_DN_MOVE: begin
				cmp_a = kid_q;
				cmp_b = cur_q;
				we    = 1'b1;
				if (above) begin
					wdata   = kid_q;
					pos_d   = kidpos_q;
					state_d = ST_DN_RDL;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (slot_free) begin
					done    = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign busy               = (state_q != ST_IDLE);
	assign result.top_value   = (cnt_q != '0) ? top_q : '0;
	assign result.entry_count = COUNT_WIDTH'(cnt_q);
	assign result.is_empty    = (cnt_q == '0);
	assign result.op_error    = err_q;

endmodule

// ----- hw/rtl/binary_heap_priority_queue_core.sv -----
// ----------------------------------------------------------------------------
// binary_heap_priority_queue_core
// Array-backed binary heap of signed values with insert, delete-top, peek
// and clear, one result item per request item.
// ----------------------------------------------------------------------------
// One request item is taken at a time, and the input stalls until its sift
// is done and its result is handed on. Peek, clear, any flagged request and
// a delete of the only entry skip the sift. An insert reads the parent and
// compares at each level it rises. A delete reads the last entry, then at
// each level reads the children, compares them when both exist, and moves
// the chosen child up while it outranks the value. The heap RAM has one
// read and one write port and registered read data, and there is one
// shared comparator. The result waits in an output register, so the next
// request item is taken while it is pending; that item then holds in its
// last step until the output register frees up.
// order_mode is written through the cfg channel; cfg_ready is low while a
// request item is offered or in progress.
module binary_heap_priority_queue_core
	import hpq_pkg::*;
#(
	parameter int CAPACITY = 1024
) (
	input  logic clk,
	input  logic arst_n,

	input  logic cfg_valid,
	output logic cfg_ready,
	input  logic cfg_data,

	input  logic req_valid,
	output logic req_stall,
	input  req_t req_item,

	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_item
);

	logic order_mode_q;
	logic rsp_valid_q;
	rsp_t rsp_item_q;

	logic busy;
	logic done;
	logic slot_free;
	rsp_t result;

	assign cfg_ready = !busy && !req_valid;
	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign req_stall = busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_mode_q <= 1'b0;
			rsp_valid_q  <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				order_mode_q <= cfg_data;
			end
			if (done) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (done) begin
			rsp_item_q <= result;
		end
	end

	hpq_seq #(
		.CAPACITY(CAPACITY)
	) u_seq (
		.clk       (clk),
		.arst_n    (arst_n),
		.order_mode(order_mode_q),
		.start     (req_valid && !req_stall),
		.item      (req_item),
		.slot_free (slot_free),
		.busy      (busy),
		.done      (done),
		.result    (result)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp_item  = rsp_item_q;

endmodule

// ----- dv/tb_binary_heap_priority_queue_core.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_binary_heap_priority_queue_core
// Self-checking bench for the heap core. A short table of hand-picked
// requests (some with typed-in answers) runs first. Random phases follow in
// both orderings: one phase fills the heap past capacity, one holds back
// results until the core backs up, and one runs with no idling at all.
// Every result is checked field by field, against the typed-in answer
// where one is given and else against a shadow heap kept in the bench.
// ----------------------------------------------------------------------------
module tb_binary_heap_priority_queue_core;
	import hpq_pkg::*;

	localparam int HEAP_DEPTH     = 1024;
	localparam int QUIET_LIMIT    = 5000;
	localparam int HOLDOFF_CYCLES = 400;
	localparam int PLAN_ROWS      = 24;

	localparam logic signed [VALUE_WIDTH-1:0] VAL_MIN = 32'sh8000_0000;
	localparam logic signed [VALUE_WIDTH-1:0] VAL_MAX = 32'sh7FFF_FFFF;

	typedef struct {
		action_t                       act;
		logic signed [VALUE_WIDTH-1:0] val;
		bit                            typed;
		rsp_t                          want;
	} row_t;

	logic clk;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic cfg_data;
	logic req_valid;
	logic req_stall;
	req_t req_item;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_item;

	logic signed [VALUE_WIDTH-1:0] heap_shadow [HEAP_DEPTH];
	int unsigned shadow_len;
	bit          max_first;
	rsp_t        rsp_owed [$];

	row_t plan [PLAN_ROWS];
	int   mismatch_cnt;
	int   quiet_cycles;
	int   order_writes;
	int   rejected;
	int   peak_len;
	int   results_seen;
	int   act_tally [4];
	bit   holdoff_req;
	bit   no_idle;

	binary_heap_priority_queue_core #(
		.CAPACITY(HEAP_DEPTH)
	) uut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_item (req_item),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_item (rsp_item)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	function automatic bit outranks(input logic signed [VALUE_WIDTH-1:0] a,
			input logic signed [VALUE_WIDTH-1:0] b);
		return max_first ? (a > b) : (a < b);
	endfunction

	function automatic void swap_shadow(input int unsigned a, input int unsigned b);
		logic signed [VALUE_WIDTH-1:0] tmp;
		tmp = heap_shadow[a];
		heap_shadow[a] = heap_shadow[b];
		heap_shadow[b] = tmp;
	endfunction

	function automatic rsp_t heap_apply(input req_t it);
		rsp_t        r;
		int unsigned pos;
		int unsigned pick;
		bit          done;
		r = '0;
		case (it.action)
			ACT_INSERT: begin
				if (shadow_len >= HEAP_DEPTH) begin
					r.op_error = 1'b1;
				end else begin
					pos = shadow_len;
					heap_shadow[pos] = it.value;
					shadow_len++;
					while (pos > 0 && outranks(heap_shadow[pos], heap_shadow[(pos - 1) / 2])) begin
						swap_shadow(pos, (pos - 1) / 2);
						pos = (pos - 1) / 2;
					end
				end
			end
			ACT_DELETE: begin
				if (shadow_len == 0) begin
					r.op_error = 1'b1;
				end else begin
					shadow_len--;
					heap_shadow[0] = heap_shadow[shadow_len];
					pos = 0;
					done = 1'b0;
					while (!done) begin
						pick = 2 * pos + 1;
						if (pick >= shadow_len) begin
							done = 1'b1;
						end else begin
							if (pick + 1 < shadow_len &&
									outranks(heap_shadow[pick + 1], heap_shadow[pick]))
								pick++;
							if (outranks(heap_shadow[pick], heap_shadow[pos])) begin
								swap_shadow(pick, pos);
								pos = pick;
							end else begin
								done = 1'b1;
							end
						end
					end
				end
			end
			ACT_CLEAR: shadow_len = 0;
			default: ;
		endcase
		r.top_value   = (shadow_len > 0) ? heap_shadow[0] : '0;
		r.entry_count = COUNT_WIDTH'(shadow_len);
		r.is_empty    = (shadow_len == 0);
		return r;
	endfunction

	function automatic rsp_t mk_rsp(input logic signed [VALUE_WIDTH-1:0] top,
			input int cnt, input bit err);
		rsp_t r;
		r.top_value   = top;
		r.entry_count = COUNT_WIDTH'(cnt);
		r.is_empty    = (cnt == 0);
		r.op_error    = err;
		return r;
	endfunction

	function automatic logic signed [VALUE_WIDTH-1:0] pick_value();
		case ($urandom_range(9))
			0:       return VAL_MIN;
			1:       return VAL_MAX;
			2, 3:    return $signed(32'($urandom_range(16))) - 32'sd8;
			default: return $signed(32'($urandom()));
		endcase
	endfunction

	task automatic flag_mismatch(input string what);
		mismatch_cnt++;
		$display("mismatch at %0t ns: %s", $time, what);
	endtask

	task automatic push_request(input action_t act, input logic signed [VALUE_WIDTH-1:0] val,
			input bit typed, input rsp_t want);
		req_t it;
		rsp_t pred;
		it.action = act;
		it.value  = val;
		req_valid <= 1'b1;
		req_item  <= it;
		do @(posedge clk); while (req_stall);
		pred = heap_apply(it);
		rsp_owed.push_back(typed ? want : pred);
		act_tally[act]++;
		if (pred.op_error)
			rejected++;
		if (shadow_len > peak_len)
			peak_len = shadow_len;
	endtask

	task automatic sender_gap();
		if (!no_idle && $urandom_range(99) < 11) begin
			req_valid <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
	endtask

	task automatic drain();
		req_valid <= 1'b0;
		do @(posedge clk); while (rsp_owed.size() != 0);
	endtask

	task automatic set_order(input bit mode);
		cfg_valid <= 1'b1;
		cfg_data  <= mode;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		max_first = mode;
		order_writes++;
	endtask

	task automatic run_phase(input int n, input int w_ins, input int w_del, input int w_peek,
			input int holdoff_at, input int pause_at);
		int      r;
		action_t act;
		for (int i = 0; i < n; i++) begin
			if (i == holdoff_at)
				holdoff_req = 1'b1;
			if (i == pause_at)
				drain();
			r = $urandom_range(999);
			if (r < w_ins)
				act = ACT_INSERT;
			else if (r < w_ins + w_del)
				act = ACT_DELETE;
			else if (r < w_ins + w_del + w_peek)
				act = ACT_PEEK;
			else
				act = ACT_CLEAR;
			push_request(act, pick_value(), 1'b0, '0);
			sender_gap();
		end
	endtask

	task automatic fill_heap();
		logic signed [VALUE_WIDTH-1:0] v;
		for (int i = 0; i < HEAP_DEPTH + 3; i++) begin
			v = (i < HEAP_DEPTH / 2) ? $signed(32'(i) * 32'd4099 + 32'h8000_0000) : pick_value();
			push_request(ACT_INSERT, v, 1'b0, '0);
			sender_gap();
		end
		push_request(ACT_PEEK, pick_value(), 1'b0, '0);
		for (int i = 0; i < 40; i++) begin
			push_request(ACT_DELETE, pick_value(), 1'b0, '0);
			sender_gap();
		end
		push_request(ACT_INSERT, VAL_MAX, 1'b0, '0);
		push_request(ACT_INSERT, VAL_MIN, 1'b0, '0);
		push_request(ACT_CLEAR, pick_value(), 1'b0, '0);
	endtask

	// result side: random stall, long hold-off on request
	initial begin
		int hold_left;
		hold_left = 0;
		rsp_stall <= 1'b0;
		forever begin
			@(posedge clk);
			if (holdoff_req) begin
				hold_left = HOLDOFF_CYCLES;
				holdoff_req = 1'b0;
			end
			if (hold_left > 0) begin
				rsp_stall <= 1'b1;
				hold_left--;
			end else if (no_idle || !arst_n) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(99) < 11);
			end
		end
	end

	always @(posedge clk) begin
		rsp_t want;
		if (arst_n && rsp_valid && !rsp_stall) begin
			if (rsp_owed.size() == 0) begin
				flag_mismatch("result item with nothing owed");
			end else begin
				want = rsp_owed.pop_front();
				results_seen++;
				if (rsp_item.top_value !== want.top_value)
					flag_mismatch($sformatf("top_value got %0d want %0d",
						rsp_item.top_value, want.top_value));
				if (rsp_item.entry_count !== want.entry_count)
					flag_mismatch($sformatf("entry_count got %0d want %0d",
						rsp_item.entry_count, want.entry_count));
				if (rsp_item.is_empty !== want.is_empty)
					flag_mismatch($sformatf("is_empty got %b want %b",
						rsp_item.is_empty, want.is_empty));
				if (rsp_item.op_error !== want.op_error)
					flag_mismatch($sformatf("op_error got %b want %b",
						rsp_item.op_error, want.op_error));
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
					(cfg_valid && cfg_ready)) begin
				quiet_cycles = 0;
			end else begin
				quiet_cycles++;
				if (quiet_cycles >= QUIET_LIMIT) begin
					$display("no handshake for %0d cycles, %0d results owed",
						quiet_cycles, rsp_owed.size());
					$display("[FAIL] regression broken");
					$finish;
				end
			end
		end
	end

	initial begin
		arst_n     = 1'b0;
		cfg_valid  = 1'b0;
		cfg_data   = 1'b0;
		req_valid  = 1'b0;
		req_item   = '0;
		shadow_len = 0;
		max_first  = 1'b0;
		plan = '{
			'{ACT_PEEK,   32'sd0,          1'b1, mk_rsp(0, 0, 1'b0)},
			'{ACT_DELETE, 32'sd0,          1'b1, mk_rsp(0, 0, 1'b1)},
			'{ACT_CLEAR,  32'sd0,          1'b1, mk_rsp(0, 0, 1'b0)},
			'{ACT_INSERT, VAL_MAX,         1'b1, mk_rsp(VAL_MAX, 1, 1'b0)},
			'{ACT_INSERT, VAL_MIN,         1'b1, mk_rsp(VAL_MIN, 2, 1'b0)},
			'{ACT_PEEK,   32'sh5555_5555,  1'b1, mk_rsp(VAL_MIN, 2, 1'b0)},
			'{ACT_DELETE, 32'sd0,          1'b1, mk_rsp(VAL_MAX, 1, 1'b0)},
			'{ACT_DELETE, 32'sd0,          1'b1, mk_rsp(0, 0, 1'b0)},
			'{ACT_DELETE, 32'sd0,          1'b1, mk_rsp(0, 0, 1'b1)},
			'{ACT_INSERT, 32'sd0,          1'b1, mk_rsp(0, 1, 1'b0)},
			'{ACT_INSERT, -32'sd1,         1'b1, mk_rsp(-1, 2, 1'b0)},
			'{ACT_INSERT, 32'sd5,          1'b0, '0},
			'{ACT_INSERT, 32'sd5,          1'b0, '0},
			'{ACT_INSERT, 32'shAAAA_AAAA,  1'b0, '0},
			'{ACT_INSERT, 32'sh5555_5555,  1'b0, '0},
			'{ACT_INSERT, -32'sd1,         1'b0, '0},
			'{ACT_DELETE, 32'sd0,          1'b0, '0},
			'{ACT_DELETE, 32'sd0,          1'b0, '0},
			'{ACT_PEEK,   32'shFFFF_FFFF,  1'b0, '0},
			'{ACT_DELETE, 32'sd0,          1'b0, '0},
			'{ACT_CLEAR,  32'sd0,          1'b1, mk_rsp(0, 0, 1'b0)},
			'{ACT_INSERT, 32'sd3,          1'b1, mk_rsp(3, 1, 1'b0)},
			'{ACT_INSERT, 32'sh7FFF_FFFE,  1'b0, '0},
			'{ACT_CLEAR,  32'shFFFF_FFFF,  1'b1, mk_rsp(0, 0, 1'b0)}
		};
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i]) begin
			push_request(plan[i].act, plan[i].val, plan[i].typed, plan[i].want);
			sender_gap();
		end

		drain();
		set_order(1'b1);
		run_phase(175, 520, 330, 140, 60, -1);

		drain();
		set_order(1'b0);
		run_phase(175, 330, 550, 110, -1, 80);

		drain();
		set_order(1'b1);
		fill_heap();

		drain();
		set_order(1'b0);
		no_idle = 1'b1;
		run_phase(175, 560, 300, 130, -1, -1);
		no_idle = 1'b0;

		drain();
		set_order(1'b1);
		run_phase(175, 500, 350, 140, -1, -1);

		drain();
		repeat (40) @(posedge clk);

		$display("run covered %0d inserts, %0d deletes, %0d peeks, %0d clears; %0d results",
			act_tally[ACT_INSERT], act_tally[ACT_DELETE], act_tally[ACT_PEEK],
			act_tally[ACT_CLEAR], results_seen);
		$display("%0d requests hit a full or empty heap, peak depth %0d of %0d, %0d order writes",
			rejected, peak_len, HEAP_DEPTH, order_writes);
		if (mismatch_cnt == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

// ----- sim.f -----
hw/rtl/hpq_pkg.sv
hw/rtl/hpq_ram.sv
hw/rtl/hpq_cmp.sv
hw/rtl/hpq_seq.sv
hw/rtl/binary_heap_priority_queue_core.sv
dv/tb_binary_heap_priority_queue_core.sv
